FILE: rtl/exclusive_pump_channel_controller_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the exclusive pump channel controller
// Concurrent checks on clk with arst_n; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef EXCLUSIVE_PUMP_CHANNEL_CONTROLLER_ASSERT_SVH
`define EXCLUSIVE_PUMP_CHANNEL_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define EPCC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("epcc assertion failed");
`define EPCC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("epcc assertion failed");
`else
`define EPCC_ASSERT_NOW(lbl, ante, cons)
`define EPCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/epcc_pkg.sv
// ----------------------------------------------------------------------------
// Exclusive pump channel controller package
// Item types, command and status codes shared by the controller modules.
// ----------------------------------------------------------------------------
package epcc_pkg;

	localparam int DEF_CHANNELS = 4;
	localparam logic [31:0] DEF_MAX_RUN_RESET = 32'd300000;

	typedef enum logic [2:0] {
		KIND_TICK      = 3'd0,
		KIND_TURN_ON   = 3'd1,
		KIND_TURN_OFF  = 3'd2,
		KIND_FORCE_OFF = 3'd3,
		KIND_ALL_OFF   = 3'd4,
		KIND_ESTOP     = 3'd5,
		KIND_QUERY     = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_INVALID     = 3'd1,
		ST_OTHER_ON    = 3'd2,
		ST_HALTED      = 3'd3,
		ST_ALREADY_ON  = 3'd4,
		ST_ALREADY_OFF = 3'd5
	} status_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  channel;
		logic [31:0] max_run_ms;
		logic        critical_error;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  pump_lines;
		logic        any_active;
		logic [1:0]  active_channel;
		logic [31:0] run_time_ms;
		logic [31:0] remaining_ms;
		logic [31:0] last_duration_ms;
		logic        timed_out;
		logic        channel_on;
		logic [31:0] channel_total_ms;
		logic [31:0] channel_activations;
		logic        halted;
	} rsp_t;

	// Statistics access for one item: read of the addressed channel and
	// read-modify-write of the channel whose run ended or started.
	typedef struct packed {
		logic [3:0]  rd_ch;
		logic        rd_ok;
		logic        upd;
		logic [3:0]  tgt;
		logic [31:0] add_total;
		logic        inc_act;
	} stat_req_t;

	typedef struct packed {
		logic [31:0] acts;
		logic [31:0] total;
	} stat_ent_t;

endpackage

FILE: rtl/epcc_stats.sv
// ----------------------------------------------------------------------------
// Channel statistics memory
// On-time totals and activation counts in a synchronous memory with two
// read ports, one write port, write forwarding and per-entry valid bits.
// ----------------------------------------------------------------------------
module epcc_stats #(
	parameter int CHANNELS = epcc_pkg::DEF_CHANNELS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  epcc_pkg::stat_req_t req,
	input  logic                fire,
	output logic [31:0]         ch_total,
	output logic [31:0]         ch_acts
);
	import epcc_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	stat_ent_t           mem [CHANNELS];
	stat_ent_t           rd_a_q;
	stat_ent_t           rd_b_q;
	stat_req_t           req_s1;
	logic [CHANNELS-1:0] ent_vld_q;
	logic                wr_en_q;
	logic [AW-1:0]       wr_addr_q;
	stat_ent_t           wr_data_q;
	logic [AW-1:0]       addr_a;
	logic [AW-1:0]       addr_b;
	logic [AW-1:0]       addr_a_s1;
	logic [AW-1:0]       addr_b_s1;
	stat_ent_t           cur_a;
	stat_ent_t           cur_b;
	stat_ent_t           upd_b;

	assign addr_a    = req.rd_ok ? req.rd_ch[AW-1:0] : '0;
	assign addr_b    = req.upd ? req.tgt[AW-1:0] : '0;
	assign addr_a_s1 = req_s1.rd_ok ? req_s1.rd_ch[AW-1:0] : '0;
	assign addr_b_s1 = req_s1.upd ? req_s1.tgt[AW-1:0] : '0;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= mem[addr_a];
			rd_b_q <= mem[addr_b];
			req_s1 <= req;
		end
		if (fire && req_s1.upd) begin
			mem[addr_b_s1] <= upd_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			wr_en_q   <= 1'b0;
			wr_addr_q <= '0;
			wr_data_q <= '0;
		end else if (fire && req_s1.upd) begin
			ent_vld_q[addr_b_s1] <= 1'b1;
			wr_en_q              <= 1'b1;
			wr_addr_q            <= addr_b_s1;
			wr_data_q            <= upd_b;
		end
	end

	always_comb begin
		if (wr_en_q && wr_addr_q == addr_a_s1) begin
			cur_a = wr_data_q;
		end else if (ent_vld_q[addr_a_s1]) begin
			cur_a = rd_a_q;
		end else begin
			cur_a = '0;
		end
		if (wr_en_q && wr_addr_q == addr_b_s1) begin
			cur_b = wr_data_q;
		end else if (ent_vld_q[addr_b_s1]) begin
			cur_b = rd_b_q;
		end else begin
			cur_b = '0;
		end
		upd_b.total = cur_b.total + req_s1.add_total;
		upd_b.acts  = cur_b.acts + {31'd0, req_s1.inc_act};
		if (!req_s1.rd_ok) begin
			ch_total = '0;
			ch_acts  = '0;
		end else if (req_s1.upd && addr_b_s1 == addr_a_s1) begin
			ch_total = upd_b.total;
			ch_acts  = upd_b.acts;
		end else begin
			ch_total = cur_a.total;
			ch_acts  = cur_a.acts;
		end
	end

endmodule

FILE: rtl/epcc_ctl.sv
// ----------------------------------------------------------------------------
// Pump run control
// Decodes one command item per cycle while acc is high, against the run
// registers and the halt latch, and issues the matching statistics access.
// ----------------------------------------------------------------------------
module epcc_ctl #(
	parameter int CHANNELS = epcc_pkg::DEF_CHANNELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  epcc_pkg::cmd_t       cmd,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata,
	output epcc_pkg::rsp_t       info,
	output epcc_pkg::stat_req_t  req
);
	import epcc_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [4:0] CH_LIM = 5'(CHANNELS);

	logic [31:0]   def_max_q;
	logic          ra_q, ra_n;
	logic [AW-1:0] rc_q, rc_n;
	logic [31:0]   rl_q, rl_n;
	logic [31:0]   re_q, re_n;
	logic          hl_q, hl_n;
	logic          ch_ok;
	logic [AW-1:0] ch_a;
	logic          is_on;
	logic [31:0]   e1;
	logic [32:0]   diff;
	logic [2:0]    status;
	logic [31:0]   last;
	logic          tmo;
	logic [3:0]    lines;

	always_comb begin
		ch_ok = {1'b0, cmd.channel} < CH_LIM;
		ch_a  = ch_ok ? cmd.channel[AW-1:0] : '0;
		is_on = ch_ok && ra_q && rc_q == ch_a;
		e1    = re_q + 32'd1;
		ra_n  = ra_q;
		rc_n  = rc_q;
		rl_n  = rl_q;
		re_n  = re_q;
		hl_n  = hl_q;
		status = ST_OK;
		last  = '0;
		tmo   = 1'b0;
		req.rd_ch     = cmd.channel;
		req.rd_ok     = ch_ok;
		req.upd       = 1'b0;
		req.tgt       = 4'(rc_q);
		req.add_total = '0;
		req.inc_act   = 1'b0;
		case (cmd.kind)
			KIND_TICK: begin
				if (ra_q) begin
					re_n = e1;
					if (rl_q != '0 && e1 >= rl_q) begin
						last = e1;
						tmo  = 1'b1;
						req.upd = 1'b1;
						ra_n = 1'b0;
						rc_n = '0;
						rl_n = '0;
						re_n = '0;
					end
				end
			end
			KIND_TURN_ON: begin
				if (!ch_ok) begin
					status = ST_INVALID;
				end else if (hl_q || cmd.critical_error) begin
					status = ST_HALTED;
				end else if (ra_q && rc_q != ch_a) begin
					status = ST_OTHER_ON;
				end else if (is_on) begin
					status = ST_ALREADY_ON;
				end else begin
					rl_n = (cmd.max_run_ms != '0) ? cmd.max_run_ms : def_max_q;
					rc_n = ch_a;
					ra_n = 1'b1;
					re_n = '0;
					req.upd     = 1'b1;
					req.tgt     = cmd.channel;
					req.inc_act = 1'b1;
				end
			end
			KIND_TURN_OFF, KIND_FORCE_OFF: begin
				if (!ch_ok) begin
					status = ST_INVALID;
				end else if (is_on) begin
					last = re_q;
					req.upd = 1'b1;
					ra_n = 1'b0;
					rc_n = '0;
					rl_n = '0;
					re_n = '0;
				end else if (cmd.kind == KIND_TURN_OFF) begin
					status = ST_ALREADY_OFF;
				end
			end
			KIND_ALL_OFF, KIND_ESTOP: begin
				if (ra_q) begin
					last = re_q;
					req.upd = 1'b1;
				end
				ra_n = 1'b0;
				rc_n = '0;
				rl_n = '0;
				re_n = '0;
				if (cmd.kind == KIND_ESTOP) begin
					hl_n = 1'b1;
				end
			end
			default: begin
			end
		endcase
		req.add_total = last;
		for (int i = 0; i < 4; i++) begin
			lines[i] = !(i < CHANNELS && ra_n && rc_n == AW'(i));
		end
		diff = {1'b0, rl_n} - {1'b0, re_n};
		info.status           = status;
		info.pump_lines       = lines;
		info.any_active       = ra_n;
		info.active_channel   = ra_n ? 2'(rc_n) : 2'd0;
		info.run_time_ms      = ra_n ? re_n : '0;
		info.remaining_ms     = (ra_n && !diff[32]) ? diff[31:0] : '0;
		info.last_duration_ms = last;
		info.timed_out        = tmo;
		info.channel_on       = ch_ok && ra_n && rc_n == ch_a;
		info.channel_total_ms = '0;
		info.channel_activations = '0;
		info.halted           = hl_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_max_q <= DEF_MAX_RUN_RESET;
			ra_q <= 1'b0;
			rc_q <= '0;
			rl_q <= '0;
			re_q <= '0;
			hl_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				def_max_q <= cfg_wdata;
			end
			if (acc) begin
				ra_q <= ra_n;
				rc_q <= rc_n;
				rl_q <= rl_n;
				re_q <= re_n;
				hl_q <= hl_n;
			end
		end
	end

endmodule

FILE: rtl/exclusive_pump_channel_controller.sv
// ----------------------------------------------------------------------------
// Exclusive pump channel controller
// Drives up to CHANNELS active-low pump relays with at most one running at a
// time, under tick, turn-on, turn-off, force-off, all-off, emergency-stop and
// query command items, and returns one status item per command. The block
// takes one item every cycle while cmd_stall is low. The run registers decide
// each item in the cycle it is taken, when the per-channel statistics memory
// is also read; the item then waits in a stage register until the output is
// not stalled, and the memory is updated as its result enters the output
// register, with the last write forwarded to the item behind it. Valid bits
// make the statistics read as zero after reset, so no clearing pass is needed.
// The run-limit register may be written only while no item is in flight.
// ----------------------------------------------------------------------------
`include "exclusive_pump_channel_controller_assert.svh"

module exclusive_pump_channel_controller #(
	parameter int CHANNELS = epcc_pkg::DEF_CHANNELS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  epcc_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output epcc_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_wdata
);
	import epcc_pkg::*;

	logic      acc;
	logic      fire;
	logic      s1_valid;
	rsp_t      info;
	rsp_t      info_s1;
	rsp_t      rsp_d;
	stat_req_t req;
	logic [31:0] ch_total;
	logic [31:0] ch_acts;

	assign fire      = s1_valid && (!rsp_valid || !rsp_stall);
	assign cmd_stall = s1_valid && !fire;
	assign acc       = cmd_valid && !cmd_stall;

	epcc_ctl #(
		.CHANNELS(CHANNELS)
	) u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.info     (info),
		.req      (req)
	);

	epcc_stats #(
		.CHANNELS(CHANNELS)
	) u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.req     (req),
		.fire    (fire),
		.ch_total(ch_total),
		.ch_acts (ch_acts)
	);

	always_comb begin
		rsp_d                     = info_s1;
		rsp_d.channel_total_ms    = ch_total;
		rsp_d.channel_activations = ch_acts;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			info_s1 <= info;
		end
		if (fire) begin
			rsp <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (acc) begin
				s1_valid <= 1'b1;
			end else if (fire) begin
				s1_valid <= 1'b0;
			end
			if (fire) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	`EPCC_ASSERT_NOW(a_one_pump, rsp_valid, $countones(~rsp.pump_lines) <= 1)
	`EPCC_ASSERT_NOW(a_timeout_ends, rsp_valid && rsp.timed_out, !rsp.any_active && |rsp.last_duration_ms)
	`EPCC_ASSERT_NOW(a_chan_on, rsp_valid && rsp.channel_on, rsp.any_active)
	`EPCC_ASSERT_NEXT(a_accept_holds, acc, s1_valid)

endmodule
